// ===== sv/tcw_pkg.sv =====
`timescale 1ns / 1ps
package tcw_pkg;

  // Default geometry of the character cell buffer.
  localparam int COLUMNS_DEF   = 80;
  localparam int ROWS_DEF      = 25;
  localparam int TAB_WIDTH_DEF = 8;

  // Field widths fixed by the interface.
  localparam int CMD_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int IDX_W     = 11;
  localparam int OUT_LOC_W = 11;
  localparam int WORD_W    = 16;
  localparam int ATTR_W    = 8;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 32;

  // Configuration port.
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam logic [1:0] REG_TEXT_ATTR   = 2'd0;
  localparam logic [1:0] REG_SCROLL_ATTR = 2'd1;
  localparam logic [1:0] REG_CLEAR_ATTR  = 2'd2;

  localparam logic [ATTR_W-1:0] TEXT_ATTR_RST   = 8'h07;
  localparam logic [ATTR_W-1:0] SCROLL_ATTR_RST = 8'h07;
  localparam logic [ATTR_W-1:0] CLEAR_ATTR_RST  = 8'h0F;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
  localparam logic [CHAR_W-1:0] CH_FIRST = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;

  // Sequencer to cursor unit.
  typedef struct packed {
    logic step;
    logic home;
  } tcw_cur_ctl_t;

  // Cursor unit to sequencer.
  typedef struct packed {
    logic wr_en;
    logic scroll;
  } tcw_cur_stat_t;

endpackage

// ===== sv/tcw_ram.sv =====
`timescale 1ns / 1ps
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/tcw_cfg.sv =====
`timescale 1ns / 1ps
module tcw_cfg
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [ATTR_W-1:0] text_attr,
  output logic [ATTR_W-1:0] scroll_attr,
  output logic [ATTR_W-1:0] clear_attr
);

  logic [ATTR_W-1:0] text_attr_r, scroll_attr_r, clear_attr_r;
  logic              wr;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r   <= TEXT_ATTR_RST;
      scroll_attr_r <= SCROLL_ATTR_RST;
      clear_attr_r  <= CLEAR_ATTR_RST;
    end else if (wr) begin
      case (reg_idx)
        REG_TEXT_ATTR:   text_attr_r   <= pwdata[ATTR_W-1:0];
        REG_SCROLL_ATTR: scroll_attr_r <= pwdata[ATTR_W-1:0];
        REG_CLEAR_ATTR:  clear_attr_r  <= pwdata[ATTR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TEXT_ATTR:   prdata = CFG_DW'(text_attr_r);
      REG_SCROLL_ATTR: prdata = CFG_DW'(scroll_attr_r);
      REG_CLEAR_ATTR:  prdata = CFG_DW'(clear_attr_r);
      default:         prdata = '0;
    endcase
  end

  assign text_attr   = text_attr_r;
  assign scroll_attr = scroll_attr_r;
  assign clear_attr  = clear_attr_r;

endmodule

// ===== sv/tcw_cursor.sv =====
`timescale 1ns / 1ps
module tcw_cursor
  import tcw_pkg::*;
#(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int ROWS      = ROWS_DEF,
  parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tcw_cur_ctl_t                      ctl,
  input  logic [CHAR_W-1:0]                 code,
  output tcw_cur_stat_t                     stat,
  output logic [$clog2(COLUMNS*ROWS)-1:0]   loc_cur,
  output logic [$clog2(COLUMNS*ROWS)-1:0]   loc_nxt
);

  localparam int AW  = $clog2(COLUMNS * ROWS);
  localparam int CW  = $clog2(COLUMNS);
  localparam int RW  = $clog2(ROWS);
  localparam int RW1 = RW + 1;
  localparam int MW  = $clog2(TAB_WIDTH);
  localparam int EW  = $clog2(COLUMNS + TAB_WIDTH + 1);

  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  // Column modulo the tab width, kept alongside the column.
  logic [MW-1:0]  mod_r, mod_nxt;
  logic [EW-1:0]  col_e;
  logic [RW1-1:0] row_e;
  logic           wr_en, scroll;

  always_comb begin
    col_e  = EW'(col_r);
    row_e  = RW1'(row_r);
    mod_nxt = mod_r;
    wr_en  = 1'b0;
    scroll = 1'b0;
    case (code)
      CH_BS: begin
        if (col_r != '0) begin
          col_e   = EW'(col_r) - EW'(1);
          mod_nxt = (mod_r == '0) ? MW'(TAB_WIDTH - 1) : mod_r - MW'(1);
        end
      end
      CH_TAB: begin
        col_e   = EW'(col_r) + EW'(TAB_WIDTH) - EW'(mod_r);
        mod_nxt = '0;
      end
      CH_CR: begin
        col_e   = '0;
        mod_nxt = '0;
      end
      CH_LF: begin
        col_e   = '0;
        row_e   = RW1'(row_r) + RW1'(1);
        mod_nxt = '0;
      end
      default: begin
        if (code inside {[CH_FIRST:CH_LAST]}) begin
          wr_en   = 1'b1;
          col_e   = EW'(col_r) + EW'(1);
          mod_nxt = (mod_r == MW'(TAB_WIDTH - 1)) ? '0 : mod_r + MW'(1);
        end
      end
    endcase
    if (col_e >= EW'(COLUMNS)) begin
      col_e   = '0;
      row_e   = row_e + RW1'(1);
      mod_nxt = '0;
    end
    // Running past the last row keeps the cursor on it; the buffer scrolls.
    if (row_e >= RW1'(ROWS)) begin
      row_e  = RW1'(ROWS - 1);
      scroll = 1'b1;
    end
    col_nxt = CW'(col_e);
    row_nxt = RW'(row_e);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      mod_r <= '0;
    end else if (ctl.home) begin
      col_r <= '0;
      row_r <= '0;
      mod_r <= '0;
    end else if (ctl.step) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      mod_r <= mod_nxt;
    end
  end

  assign stat.wr_en  = wr_en;
  assign stat.scroll = scroll;
  assign loc_cur = AW'(int'(row_r) * COLUMNS) + AW'(col_r);
  assign loc_nxt = AW'(int'(row_nxt) * COLUMNS) + AW'(col_nxt);

endmodule

// ===== sv/tcw_seq.sv =====
`timescale 1ns / 1ps
module tcw_seq
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [CMD_W-1:0]                in_cmd,
  input  logic [CHAR_W-1:0]               in_code,
  input  logic [IDX_W-1:0]                in_idx,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_LOC_W-1:0]            out_loc,
  output logic [WORD_W-1:0]               out_word,
  input  logic [ATTR_W-1:0]               text_attr,
  input  logic [ATTR_W-1:0]               scroll_attr,
  input  logic [ATTR_W-1:0]               clear_attr,
  output tcw_cur_ctl_t                    cur_ctl,
  input  tcw_cur_stat_t                   cur_stat,
  input  logic [$clog2(COLUMNS*ROWS)-1:0] loc_cur,
  input  logic [$clog2(COLUMNS*ROWS)-1:0] loc_nxt,
  output logic                            ram_we,
  output logic [$clog2(COLUMNS*ROWS)-1:0] ram_waddr,
  output logic [WORD_W-1:0]               ram_wdata,
  output logic [$clog2(COLUMNS*ROWS)-1:0] ram_raddr,
  input  logic [WORD_W-1:0]               ram_rdata
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam logic [AW-1:0] COPY_LAST  = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0] LAST_ROW   = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_COPY   = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;
  localparam logic [2:0] S_RDWAIT = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [CMD_W-1:0]     cmd_r;
  logic [CHAR_W-1:0]    code_r;
  logic [IDX_W-1:0]     idx_r;
  logic [AW-1:0]        cnt_r, cnt_nxt;
  logic                 pend_r, pend_nxt;
  logic [AW-1:0]        pend_addr_r, pend_addr_nxt;
  logic [ATTR_W-1:0]    fill_attr_r, fill_attr_nxt;
  logic [OUT_LOC_W-1:0] res_loc_r;
  logic [WORD_W-1:0]    res_word_r;
  logic                 out_valid_r;
  logic [OUT_LOC_W-1:0] out_loc_r;
  logic [WORD_W-1:0]    out_word_r;
  logic                 accept, out_free;
  logic                 fin;
  logic [OUT_LOC_W-1:0] fin_loc;
  logic [WORD_W-1:0]    fin_word;
  logic                 idx_ok;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;
  assign idx_ok    = int'(idx_r) < CELLS;

  // A scroll reads one row ahead of the cell that it writes, so the read and
  // the delayed write of the copy never touch the same entry.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    fill_attr_nxt = fill_attr_r;
    cur_ctl       = '0;
    ram_we        = 1'b0;
    ram_waddr     = pend_addr_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = cnt_r + AW'(COLUMNS);
    fin           = 1'b0;
    fin_loc       = OUT_LOC_W'(loc_cur);
    fin_word      = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_r)
          CMD_PUT: begin
            cur_ctl.step = 1'b1;
            ram_we       = cur_stat.wr_en;
            ram_waddr    = loc_cur;
            ram_wdata    = {text_attr, code_r};
            if (cur_stat.scroll) begin
              state_nxt = S_COPY;
              cnt_nxt   = '0;
            end else begin
              fin     = 1'b1;
              fin_loc = OUT_LOC_W'(loc_nxt);
            end
          end
          CMD_CLEAR: begin
            cur_ctl.home  = 1'b1;
            state_nxt     = S_FILL;
            cnt_nxt       = '0;
            fill_attr_nxt = clear_attr;
          end
          CMD_READ: begin
            ram_raddr = AW'(idx_r);
            state_nxt = S_RDWAIT;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_COPY: begin
        ram_we        = pend_r;
        pend_nxt      = 1'b1;
        pend_addr_nxt = cnt_r;
        if (cnt_r == COPY_LAST) begin
          state_nxt     = S_FILL;
          cnt_nxt       = LAST_ROW;
          fill_attr_nxt = scroll_attr;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_FILL: begin
        ram_we = 1'b1;
        if (!pend_r) begin
          ram_waddr = cnt_r;
          ram_wdata = {fill_attr_r, CH_BLANK};
          if (cnt_r == LAST_CELL) begin
            fin = 1'b1;
          end else begin
            cnt_nxt = cnt_r + AW'(1);
          end
        end
      end
      S_RDWAIT: begin
        fin      = 1'b1;
        fin_word = idx_ok ? ram_rdata : '0;
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (fin) begin
      state_nxt = out_free ? S_IDLE : S_RESP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      if ((fin || state_r == S_RESP) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_cmd;
      code_r <= in_code;
      idx_r  <= in_idx;
    end
    cnt_r       <= cnt_nxt;
    pend_addr_r <= pend_addr_nxt;
    fill_attr_r <= fill_attr_nxt;
    if (fin) begin
      res_loc_r  <= fin_loc;
      res_word_r <= fin_word;
    end
    if (fin && out_free) begin
      out_loc_r  <= fin_loc;
      out_word_r <= fin_word;
    end else if (state_r == S_RESP && out_free) begin
      out_loc_r  <= res_loc_r;
      out_word_r <= res_word_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_loc    = out_loc_r;
  assign out_word   = out_word_r;

endmodule

// ===== sv/text_console_char_writer.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Words carried
// in_      input      command, char_code, cell_index
// out_     output     cursor_pos, cell_word
// cfg_     APB slave  text, scroll fill and clear fill attributes
//
// A put that only moves the cursor or writes one cell ends in the execute
// state; a read adds a wait state for the registered read of the cell memory.
// A clear and a put that scrolls write cells one at a time through the single
// write port of the cell memory. Reset homes the cursor and loads the attribute
// defaults; the cell memory is not cleared. A stalled result waits in the
// output register while the engine takes and works the next word.
module text_console_char_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int ROWS      = ROWS_DEF,
  parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // [1:0] command, [9:2] char_code, [20:10] cell_index
  input  logic [IN_W-1:0]   in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // [10:0] cursor_pos, [26:11] cell_word
  output logic [OUT_W-1:0]  out_tdata,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic [ATTR_W-1:0]    text_attr, scroll_attr, clear_attr;
  tcw_cur_ctl_t         cur_ctl;
  tcw_cur_stat_t        cur_stat;
  logic [AW-1:0]        loc_cur, loc_nxt;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_W-1:0]    ram_wdata, ram_rdata;
  logic [OUT_LOC_W-1:0] out_loc;
  logic [WORD_W-1:0]    out_word;
  // The cursor unit decodes the character held for the executing word.
  logic [CHAR_W-1:0]    in_code_q;

  tcw_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .text_attr   (text_attr),
    .scroll_attr (scroll_attr),
    .clear_attr  (clear_attr)
  );

  tcw_cursor #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_cursor (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cur_ctl),
    .code    (in_code_q),
    .stat    (cur_stat),
    .loc_cur (loc_cur),
    .loc_nxt (loc_nxt)
  );

  tcw_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_code_q <= in_tdata[9:2];
    end
  end

  tcw_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_cmd      (in_tdata[1:0]),
    .in_code     (in_tdata[9:2]),
    .in_idx      (in_tdata[20:10]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_loc     (out_loc),
    .out_word    (out_word),
    .text_attr   (text_attr),
    .scroll_attr (scroll_attr),
    .clear_attr  (clear_attr),
    .cur_ctl     (cur_ctl),
    .cur_stat    (cur_stat),
    .loc_cur     (loc_cur),
    .loc_nxt     (loc_nxt),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  assign out_tdata = {{(OUT_W - OUT_LOC_W - WORD_W){1'b0}}, out_word, out_loc};

endmodule

// ===== sv/tcw_checker.sv =====
`timescale 1ns / 1ps
module tcw_checker
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  localparam int CELLS = COLUMNS * ROWS;

  // A word that waits on the output side keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // The engine works on one word at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a word is executing");

  // The reported cursor always lies inside the buffer.
  a_loc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (CELLS <= 2048) |-> int'(out_tdata[OUT_LOC_W-1:0]) < CELLS)
    else $error("cursor location beyond the buffer");

  // Reset empties the output register and leaves the engine ready.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("engine not idle after reset");

endmodule

bind text_console_char_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/text_console_char_writer_tb.sv =====
`timescale 1ns / 1ps
module text_console_char_writer_tb;
  import tcw_pkg::*;

  localparam int CELL_COUNT  = COLUMNS_DEF * ROWS_DEF;
  localparam int IDX_SPAN    = 1 << IDX_W;
  localparam int ITEMS       = 1750;
  localparam int PHASE_ITEMS = (ITEMS - 20) / 3;
  // Every word could in the worst case be a scroll plus stalls on both sides.
  localparam int CYCLE_LIMIT = 4 * (ITEMS + 100) * (CELL_COUNT + 16);
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int REG_UNUSED = 3;

  typedef struct packed {
    logic [OUT_LOC_W-1:0] loc;
    logic [WORD_W-1:0]    word;
  } console_result_t;

  class console_mirror;
    bit [WORD_W-1:0] cells [CELL_COUNT];
    int unsigned     col;
    int unsigned     row;
    bit [ATTR_W-1:0] text_attr;
    bit [ATTR_W-1:0] scroll_attr;
    bit [ATTR_W-1:0] clear_attr;
    console_result_t awaited[$];
    int              errors;

    function new();
      foreach (cells[i]) cells[i] = '0;
      col         = 0;
      row         = 0;
      text_attr   = TEXT_ATTR_RST;
      scroll_attr = SCROLL_ATTR_RST;
      clear_attr  = CLEAR_ATTR_RST;
      errors      = 0;
    endfunction

    function void set_attr(int index, bit [ATTR_W-1:0] value);
      if (index == REG_TEXT_ATTR) begin
        text_attr = value;
      end else if (index == REG_SCROLL_ATTR) begin
        scroll_attr = value;
      end else if (index == REG_CLEAR_ATTR) begin
        clear_attr = value;
      end
    endfunction

    function void take_word(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                            logic [IDX_W-1:0] idx);
      console_result_t result;
      int i;
      result.word = '0;
      case (cmd)
        CMD_PUT: begin
          if (ch == CH_BS) begin
            if (col != 0) col--;
          end else if (ch == CH_TAB) begin
            col = col + TAB_WIDTH_DEF - (col % TAB_WIDTH_DEF);
          end else if (ch == CH_CR) begin
            col = 0;
          end else if (ch == CH_LF) begin
            col = 0;
            row++;
          end else if (ch >= CH_FIRST && ch <= CH_LAST) begin
            cells[row * COLUMNS_DEF + col] = {text_attr, ch};
            col++;
          end
          if (col >= COLUMNS_DEF) begin
            col = 0;
            row++;
          end
          // Falling off the bottom shifts every row up and blanks the last one.
          if (row >= ROWS_DEF) begin
            for (i = 0; i < CELL_COUNT - COLUMNS_DEF; i++) cells[i] = cells[i + COLUMNS_DEF];
            for (i = CELL_COUNT - COLUMNS_DEF; i < CELL_COUNT; i++)
              cells[i] = {scroll_attr, CH_BLANK};
            row = ROWS_DEF - 1;
          end
        end
        CMD_CLEAR: begin
          foreach (cells[j]) cells[j] = {clear_attr, CH_BLANK};
          col = 0;
          row = 0;
        end
        CMD_READ: begin
          if (idx < CELL_COUNT) result.word = cells[idx];
        end
        default: begin
        end
      endcase
      result.loc = OUT_LOC_W'(row * COLUMNS_DEF + col);
      awaited.push_back(result);
    endfunction

    function void check_word(logic [OUT_LOC_W-1:0] loc, logic [WORD_W-1:0] word);
      console_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing pending: cursor_pos %0d cell_word %h",
                 $time, loc, word);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (loc !== want.loc) begin
        $display("%0t: cursor_pos expected %0d, got %0d", $time, want.loc, loc);
        errors++;
      end
      if (word !== want.word) begin
        $display("%0t: cell_word expected %h, got %h", $time, want.word, word);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  // [1:0] command, [9:2] char_code, [20:10] cell_index
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // [10:0] cursor_pos, [26:11] cell_word
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  console_mirror mirror = new();
  int send_idle_pct = 16;
  int recv_idle_pct = 47;
  int items_sent = 0;
  int cycles = 0;

  text_console_char_writer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Result side: check on every accepted word, then pick the next ready level.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        mirror.check_word(out_tdata[OUT_LOC_W-1:0], out_tdata[OUT_LOC_W +: WORD_W]);
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic logic [IDX_W-1:0] any_index();
    return IDX_W'($urandom_range(0, IDX_SPAN - 1));
  endfunction

  function automatic logic [CHAR_W-1:0] any_char();
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // Holds in_tvalid across back-to-back words so it never toggles within one step.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                           input logic [IDX_W-1:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - IDX_W - CHAR_W - CMD_W){1'b0}}, idx, ch, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    mirror.take_word(cmd, ch, idx);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (mirror.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_attr(input int index, input logic [ATTR_W-1:0] value);
    logic [CFG_DW-1:0] data;
    data = $urandom();
    data[ATTR_W-1:0] = value;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(4 * index);
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    mirror.set_attr(index, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    int target;
    int kind;
    int n;
    int k;
    int pick;
    int near;
    int back;
    target = items_sent + count;
    while (items_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        // A line of text, sometimes long enough to wrap, with a typical ending.
        n = $urandom_range(1, 90);
        for (k = 0; k < n; k++)
          send_word(CMD_PUT, CHAR_W'($urandom_range(CH_FIRST, CH_LAST)), any_index());
        case ($urandom_range(0, 3))
          1: send_word(CMD_PUT, CH_CR, any_index());
          2: send_word(CMD_PUT, CH_LF, any_index());
          3: begin
            send_word(CMD_PUT, CH_CR, any_index());
            send_word(CMD_PUT, CH_LF, any_index());
          end
          default: begin
          end
        endcase
      end else if (kind < 55) begin
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) begin
          pick = $urandom_range(0, 5);
          case (pick)
            0: send_word(CMD_PUT, CH_BS, any_index());
            1: send_word(CMD_PUT, CH_TAB, any_index());
            2: send_word(CMD_PUT, CH_CR, any_index());
            3: send_word(CMD_PUT, CH_LF, any_index());
            4: send_word(CMD_PUT, CHAR_W'($urandom_range(0, 31)), any_index());
            default: send_word(CMD_PUT, CHAR_W'($urandom_range(128, 255)), any_index());
          endcase
        end
      end else if (kind < 75) begin
        // Read back mostly what was just written around the cursor.
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) begin
          near = mirror.row * COLUMNS_DEF + mirror.col;
          back = $urandom_range(0, 2 * COLUMNS_DEF);
          if ($urandom_range(0, 3) == 0)
            send_word(CMD_READ, any_char(), any_index());
          else
            send_word(CMD_READ, any_char(), IDX_W'(near > back ? near - back : 0));
        end
      end else if (kind < 78) begin
        send_word(CMD_CLEAR, any_char(), any_index());
      end else if (kind < 82) begin
        send_word(CMD_UNUSED, any_char(), any_index());
      end else if (kind < 83) begin
        wait_drained();
      end else begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) send_word(CMD_PUT, any_char(), any_index());
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Clearing first means no cell is ever read before it has been written.
    send_word(CMD_CLEAR, any_char(), any_index());
    send_word(CMD_READ, any_char(), 11'd0);
    send_word(CMD_PUT, CH_FIRST, any_index());
    send_word(CMD_PUT, CH_LAST, any_index());
    send_word(CMD_PUT, 8'h41, any_index());
    send_word(CMD_PUT, CH_BS, any_index());
    send_word(CMD_PUT, CH_CR, any_index());
    send_word(CMD_PUT, CH_BS, any_index());
    send_word(CMD_PUT, CH_TAB, any_index());
    send_word(CMD_PUT, 8'h00, any_index());
    send_word(CMD_PUT, 8'h1F, any_index());
    send_word(CMD_PUT, 8'h80, any_index());
    send_word(CMD_PUT, 8'hFF, any_index());
    send_word(CMD_PUT, CH_LF, any_index());
    send_word(CMD_UNUSED, 8'hFF, 11'h7FF);
    send_word(CMD_READ, any_char(), 11'd1);
    send_word(CMD_READ, any_char(), 11'd2);
    send_word(CMD_READ, any_char(), IDX_W'(CELL_COUNT - 1));
    send_word(CMD_READ, any_char(), IDX_W'(CELL_COUNT));
    send_word(CMD_READ, 8'h00, 11'h7FF);

    wait_drained();
    write_attr(REG_TEXT_ATTR, 8'hFF);
    write_attr(REG_SCROLL_ATTR, 8'h00);
    write_attr(REG_CLEAR_ATTR, 8'h00);
    random_phase(PHASE_ITEMS);

    wait_drained();
    send_idle_pct = 47;
    recv_idle_pct = 16;
    write_attr(REG_TEXT_ATTR, 8'h00);
    write_attr(REG_SCROLL_ATTR, 8'hFF);
    write_attr(REG_CLEAR_ATTR, 8'hFF);
    write_attr(REG_UNUSED, CHAR_W'($urandom_range(0, 255)));
    random_phase(PHASE_ITEMS);

    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_attr(REG_TEXT_ATTR, CHAR_W'($urandom_range(0, 255)));
    write_attr(REG_SCROLL_ATTR, CHAR_W'($urandom_range(0, 255)));
    write_attr(REG_CLEAR_ATTR, CHAR_W'($urandom_range(0, 255)));
    random_phase(PHASE_ITEMS);

    wait_drained();
    repeat (64) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
